### src/cwa_pkg.sv
// package for the circular window average: widths, defaults and item types
package cwa_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int WINDOW_DEF = 10;
    localparam int WINDOW_MIN = 2;
    localparam int WINDOW_MAX = 16;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                end_of_vector;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                last_result;
    } out_item_t;

endpackage

### src/cwa_stream_if.sv
// valid/ready stream interface carrying one item per handshake
interface cwa_stream_if #(
    parameter type item_t = cwa_pkg::in_item_t
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/circular_window_average.sv
// top level: circular forward moving average over a vector of samples
//
//  channel   dir  item          fields
//  -------   ---  ------------  -----------------------------------
//  feed      in   in_item_t     sample[15:0], end_of_vector
//  result    out  out_item_t    average[15:0], last_result
//
// one shared adder sums a window one sample per cycle: each result is summed,
// passed through the reciprocal multiplier and then loaded into the output
// register; an item without a result goes from idle through the store update
// back to idle, and a new item is taken only after every result of the last
// one is loaded; feed.ready is high only while idle
// a result waiting in the output register stalls the sequencer at load
// rst_n clears the sequencer, the seen count and the output valid; the
// sample stores hold garbage until written
module circular_window_average #(
    parameter int WINDOW = cwa_pkg::WINDOW_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    cwa_stream_if.sink          feed,
    cwa_stream_if.source        result
);

    localparam int DEPTH  = WINDOW - 1;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW);
    localparam int POS_W  = $clog2(2 * WINDOW - 1);
    localparam int SUM_W  = cwa_pkg::SAMPLE_W + $clog2(WINDOW);
    // round-up reciprocal: exact floor division for any sum below 2**SUM_W
    localparam int SHIFT  = SUM_W + $clog2(WINDOW);
    localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(WINDOW) - 1)
                                 / longint'(WINDOW);
    localparam logic [SHIFT:0] RECIP = (SHIFT+1)'(RECIP_L);
    localparam int PROD_W = SUM_W + SHIFT + 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SUM  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_LOAD = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t                        state_reg, state_next;
    logic [cwa_pkg::SAMPLE_W-1:0]  cur_reg, cur_next;
    logic                          eov_reg, eov_next;
    logic [SUM_W-1:0]              acc_reg, acc_next;
    logic [PROD_W-1:0]             prod_reg;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic [CNT_W-1:0]              term_reg, term_next;
    logic [CNT_W-1:0]              res_reg, res_next;
    logic [CNT_W-1:0]              seen_reg, seen_next;
    logic [cwa_pkg::SAMPLE_W-1:0]  avg_reg;
    logic                          last_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [cwa_pkg::SAMPLE_W-1:0]  recent_reg [DEPTH];
    logic [cwa_pkg::SAMPLE_W-1:0]  head_reg [DEPTH];

    logic                          full;
    logic                          last_res;
    logic                          load_ok;
    logic [cwa_pkg::SAMPLE_W-1:0]  elem;
    logic [POS_W-1:0]              head_pos;

    // full vector: window positions 0..WINDOW-2 come from the recent
    // samples, WINDOW-1 is the current sample, beyond that the head store
    assign full     = (seen_reg == CNT_W'(WINDOW - 1));
    assign head_pos = pos_reg - POS_W'(WINDOW);

    always_comb
    begin
        if (full)
        begin
            if (pos_reg < POS_W'(WINDOW - 1))
            begin
                elem = recent_reg[pos_reg[IDX_W-1:0]];
            end
            else if (pos_reg == POS_W'(WINDOW - 1))
            begin
                elem = cur_reg;
            end
            else
            begin
                elem = head_reg[head_pos[IDX_W-1:0]];
            end
        end
        else
        begin
            // short vector: head store then the current sample, wrapping
            if (pos_reg < POS_W'(seen_reg))
            begin
                elem = head_reg[pos_reg[IDX_W-1:0]];
            end
            else
            begin
                elem = cur_reg;
            end
        end
    end

    // last result of this item: one result without end of vector,
    // WINDOW results on a full vector end, seen+1 on a short one
    assign last_res = !eov_reg ? 1'b1 :
                      full     ? (res_reg == CNT_W'(WINDOW - 1)) :
                                 (res_reg == seen_reg);
    assign load_ok  = !out_valid_reg || result.ready;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        eov_next       = eov_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        term_next      = term_reg;
        res_next       = res_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (feed.valid)
                begin
                    cur_next  = feed.data.sample;
                    eov_next  = feed.data.end_of_vector;
                    acc_next  = '0;
                    pos_next  = '0;
                    term_next = '0;
                    res_next  = '0;
                    // filling the head store yields no result
                    if (!feed.data.end_of_vector && !full)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                acc_next  = acc_reg + SUM_W'(elem);
                term_next = term_reg + CNT_W'(1);
                if (!full && pos_reg == POS_W'(seen_reg))
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
                if (term_reg == CNT_W'(WINDOW - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    if (last_res)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        res_next   = res_reg + CNT_W'(1);
                        pos_next   = POS_W'(res_reg) + POS_W'(1);
                        term_next  = '0;
                        acc_next   = '0;
                        state_next = ST_SUM;
                    end
                end
            end
            ST_DONE:
            begin
                if (eov_reg)
                begin
                    seen_next = '0;
                end
                else if (!full)
                begin
                    seen_next = seen_reg + CNT_W'(1);
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            term_reg      <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            term_reg      <= term_next;
            res_reg       <= res_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        eov_reg <= eov_next;
        acc_reg <= acc_next;
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PROD_W'(acc_reg) * PROD_W'(RECIP);
        end
        if (state_reg == ST_LOAD && load_ok)
        begin
            avg_reg  <= prod_reg[SHIFT +: cwa_pkg::SAMPLE_W];
            last_reg <= eov_reg && last_res;
        end
    end

    // sample stores, updated once the item's results are all out
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                recent_reg[i] <= recent_reg[i+1];
            end
            recent_reg[DEPTH-1] <= cur_reg;
            if (!eov_reg && !full)
            begin
                head_reg[seen_reg[IDX_W-1:0]] <= cur_reg;
            end
        end
    end

    assign feed.ready               = (state_reg == ST_IDLE);
    assign result.valid             = out_valid_reg;
    assign result.data.average      = avg_reg;
    assign result.data.last_result  = last_reg;

    // seen count saturates one short of the window
    a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= CNT_W'(WINDOW - 1))
        else $error("seen count beyond window");

    // on a short vector the wrap position never passes the current sample
    a_short_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM && !full) |-> pos_reg <= POS_W'(seen_reg))
        else $error("short vector position out of range");

    // loading the final result of an item leads straight to the store update
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && load_ok && last_res) |=> state_reg == ST_DONE)
        else $error("final result not followed by store update");

    // a result is only produced after a full window sum and multiply
    a_load_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_LOAD)
        else $error("result loaded outside load state");

endmodule

### bench/tb.sv
// testbench for circular_window_average: directed table, random vectors, predictor check
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN          = cwa_pkg::WINDOW_DEF;
    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 440;
    localparam int MAX_WAIT     = 16;
    // drain time after the last expected result, sized from a full vector end of WIN results plus margin
    localparam int DRAIN_CYCLES = 4 * WIN * (WIN + 2);
    localparam int TIMEOUT_NS   = 4_000_000;
    localparam int PREDICTED    = -1;
    localparam int DIR_ROWS     = 25;

    typedef logic [cwa_pkg::SAMPLE_W-1:0] sample_t;

    // one row of the directed table; n_fixed < 0 leaves the results to the predictor
    typedef struct packed {
        sample_t sample;
        logic    eov;
        int      n_fixed;
        sample_t fixed_avg;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    cwa_stream_if #(.item_t(cwa_pkg::in_item_t))  feed_if ();
    cwa_stream_if #(.item_t(cwa_pkg::out_item_t)) result_if ();

    circular_window_average #(
        .WINDOW (WIN)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_if),
        .result (result_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // predictor state: head of the current vector, last WIN-1 samples, samples seen
    sample_t     vec_head   [WIN-1];
    sample_t     vec_recent [WIN-1];
    int unsigned vec_seen;

    cwa_pkg::out_item_t pending_averages [$];
    int                 mismatch_count = 0;
    bit                 feed_burst = 1'b0;
    bit                 sink_burst = 1'b0;

    dir_row_t directed_rows [DIR_ROWS] = '{
        // one-sample vectors: the window wraps onto the single sample
        '{16'hFFFF, 1'b1, 1, 16'hFFFF},
        '{16'h0000, 1'b1, 1, 16'h0000},
        // two-sample short vector: silent until its end
        '{16'h3039, 1'b0, 0, 16'h0000},
        '{16'hD431, 1'b1, PREDICTED, 16'h0000},
        // ten samples at full scale: the wide sum must not overflow
        '{16'hFFFF, 1'b0, 0, 16'h0000},
        '{16'hFFFF, 1'b0, 0, 16'h0000},
        '{16'hFFFF, 1'b0, 0, 16'h0000},
        '{16'hFFFF, 1'b0, 0, 16'h0000},
        '{16'hFFFF, 1'b0, 0, 16'h0000},
        '{16'hFFFF, 1'b0, 0, 16'h0000},
        '{16'hFFFF, 1'b0, 0, 16'h0000},
        '{16'hFFFF, 1'b0, 0, 16'h0000},
        '{16'hFFFF, 1'b0, 0, 16'h0000},
        '{16'hFFFF, 1'b1, WIN, 16'hFFFF},
        // eleven mixed samples: one window mid-vector, then the wrapped tail
        '{16'h8000, 1'b0, PREDICTED, 16'h0000},
        '{16'h7FFF, 1'b0, PREDICTED, 16'h0000},
        '{16'hFFFF, 1'b0, PREDICTED, 16'h0000},
        '{16'h0000, 1'b0, PREDICTED, 16'h0000},
        '{16'h0001, 1'b0, PREDICTED, 16'h0000},
        '{16'hFFFE, 1'b0, PREDICTED, 16'h0000},
        '{16'h5555, 1'b0, PREDICTED, 16'h0000},
        '{16'hAAAA, 1'b0, PREDICTED, 16'h0000},
        '{16'h1234, 1'b0, PREDICTED, 16'h0000},
        '{16'hFEDC, 1'b0, PREDICTED, 16'h0000},
        '{16'h00FF, 1'b1, PREDICTED, 16'h0000}
    };

    function automatic cwa_pkg::out_item_t window_result(input int unsigned sum,
                                                         input bit last);
        cwa_pkg::out_item_t r;
        r.average     = sample_t'(sum / WIN);
        r.last_result = last;
        return r;
    endfunction

    // works out the averages that one accepted item causes and queues them
    function automatic void predict_windows(input cwa_pkg::in_item_t it);
        int unsigned n, len, sum;
        int          p, i, k;
        sample_t     span [WIN];
        n = vec_seen;
        if (!it.end_of_vector)
        begin
            if (n < WIN - 1)
            begin
                vec_head[n] = it.sample;
                vec_seen    = n + 1;
            end
            else
            begin
                // the new sample closes the window that opened WIN-1 samples ago
                sum = it.sample;
                for (i = 0; i < WIN - 1; i++)
                    sum += vec_recent[i];
                pending_averages.push_back(window_result(sum, 1'b0));
            end
        end
        else if (n < WIN - 1)
        begin
            // short vector: every window wraps round it as often as needed
            len = n + 1;
            for (p = 0; p < n; p++)
                span[p] = vec_head[p];
            span[n] = it.sample;
            for (p = 0; p < len; p++)
            begin
                sum = 0;
                for (i = 0; i < WIN; i++)
                    sum += span[(p + i) % len];
                pending_averages.push_back(window_result(sum, p + 1 == len));
            end
            vec_seen = 0;
        end
        else
        begin
            // vector end: last full window, then windows spilling onto the head
            for (i = 0; i < WIN - 1; i++)
                span[i] = vec_recent[i];
            span[WIN-1] = it.sample;
            sum = 0;
            for (i = 0; i < WIN; i++)
                sum += span[i];
            pending_averages.push_back(window_result(sum, 1'b0));
            for (k = 0; k < WIN - 1; k++)
            begin
                sum = 0;
                for (i = k + 1; i < WIN; i++)
                    sum += span[i];
                for (i = 0; i <= k; i++)
                    sum += vec_head[i];
                pending_averages.push_back(window_result(sum, k == WIN - 2));
            end
            vec_seen = 0;
        end
        for (i = 0; i + 1 < WIN - 1; i++)
            vec_recent[i] = vec_recent[i+1];
        vec_recent[WIN-2] = it.sample;
    endfunction

    // offers one item after a random gap and predicts it once accepted
    task automatic send_item(input sample_t smp, input logic eov, input int n_fixed,
                             input sample_t fixed_avg);
        cwa_pkg::in_item_t  it;
        cwa_pkg::out_item_t fixed;
        int                 gap, base, j;
        it.sample        = smp;
        it.end_of_vector = eov;
        if ($urandom_range(0, 39) == 0)
            feed_burst = !feed_burst;
        gap = feed_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            feed_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        feed_if.valid <= 1'b1;
        feed_if.data  <= it;
        @(posedge clk);
        while (feed_if.ready !== 1'b1)
            @(posedge clk);
        base = pending_averages.size();
        predict_windows(it);
        if (n_fixed >= 0)
        begin
            // typed-in rows replace what the predictor queued
            while (pending_averages.size() > base)
                void'(pending_averages.pop_back());
            for (j = 0; j < n_fixed; j++)
            begin
                fixed.average     = fixed_avg;
                fixed.last_result = eov && (j == n_fixed - 1);
                pending_averages.push_back(fixed);
            end
        end
    endtask

    // stimulus: reset, directed table, random vectors, drain
    initial
    begin
        int      r, len, j, n_items;
        sample_t smp;
        rst_n         = 1'b0;
        feed_if.valid = 1'b0;
        feed_if.data  = '0;
        vec_seen      = 0;
        for (j = 0; j < WIN - 1; j++)
        begin
            vec_head[j]   = '0;
            vec_recent[j] = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (j = 0; j < DIR_ROWS; j++)
            send_item(directed_rows[j].sample, directed_rows[j].eov,
                      directed_rows[j].n_fixed, directed_rows[j].fixed_avg);

        // random vectors: many short ones, some at the window length, some long
        n_items = 0;
        while (n_items < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                len = $urandom_range(1, WIN - 1);
            else if (r < 50)
                len = WIN;
            else if (r < 60)
                len = WIN + 1;
            else
                len = $urandom_range(WIN + 2, 4 * WIN);
            for (j = 0; j < len; j++)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    smp = '0;
                else if (r == 1)
                    smp = '1;
                else
                    smp = sample_t'($urandom);
                send_item(smp, j == len - 1, PREDICTED, '0);
            end
            n_items += len;
        end
        feed_if.valid <= 1'b0;

        while (pending_averages.size() != 0)
            @(posedge clk);
        // stray results after the last expected one still get caught
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // result side: random stall before each item, compare with the oldest expectation
    initial
    begin
        cwa_pkg::out_item_t got, want;
        int                 stall;
        result_if.ready = 1'b0;
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            @(posedge clk);
            while (result_if.valid !== 1'b1)
                @(posedge clk);
            got = result_if.data;
            if (pending_averages.size() == 0)
            begin
                $error("unexpected result: average %0d last_result %0d",
                       got.average, got.last_result);
                mismatch_count++;
            end
            else
            begin
                want = pending_averages.pop_front();
                if (got.average !== want.average)
                begin
                    $error("average: expected %0d, got %0d", want.average, got.average);
                    mismatch_count++;
                end
                if (got.last_result !== want.last_result)
                begin
                    $error("last_result: expected %0d, got %0d",
                           want.last_result, got.last_result);
                    mismatch_count++;
                end
            end
        end
    end

    // hard stop if the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("tb: FAIL");
        $finish;
    end

endmodule
